>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the RTL files; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

>>> rtl/hmd_pkg.sv
// ----------------------------------------------------------------------------
// hmd_pkg
// Shared types and constants of the history message decoder.
// ----------------------------------------------------------------------------
package hmd_pkg;

    localparam int unsigned DefaultCapacity = 32;
    localparam logic [6:0] VarintPayloadMask = 7'h7F;
    localparam logic [2:0] WireTypeMask = 3'h7;

    // Wire types that the parser can skip or open.
    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LENGTH  = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    typedef enum logic [2:0] {
        PH_TAG      = 3'd0,
        PH_LEN      = 3'd1,
        PH_SKIPVAR  = 3'd2,
        PH_SKIPBYTES = 3'd3,
        PH_ARRAY    = 3'd4,
        PH_STOPPED  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        TGT_BASS    = 3'd0,
        TGT_LOWMID  = 3'd1,
        TGT_HIGHMID = 3'd2,
        TGT_TREBLE  = 3'd3,
        TGT_REGION  = 3'd4,
        TGT_SKIP    = 3'd5
    } target_t;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_OVERRUN = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    // One classified event from the front parser to the emitter.
    typedef struct packed {
        logic        has_word;
        logic [1:0]  band;
        logic [7:0]  index;
        logic [31:0] word;
        logic        has_end;
        logic [1:0]  status;
    } event_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

>>> rtl/hmd_parser.sv
// ----------------------------------------------------------------------------
// hmd_parser
// Front part: walks the wire format one byte per transaction and emits events.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module hmd_parser #(
    parameter int unsigned BASS_CAPACITY    = hmd_pkg::DefaultCapacity,
    parameter int unsigned LOWMID_CAPACITY  = hmd_pkg::DefaultCapacity,
    parameter int unsigned HIGHMID_CAPACITY = hmd_pkg::DefaultCapacity,
    parameter int unsigned TREBLE_CAPACITY  = hmd_pkg::DefaultCapacity
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          byte_in,
    input  logic                last_byte,
    output logic                ev_valid,
    input  logic                ev_ready,
    output hmd_pkg::event_t     ev
);
    import hmd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  vcnt_reg, vcnt_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] rend_reg, rend_next;
    logic        inreg_reg, inreg_next;
    logic [31:0] aend_reg, aend_next;
    target_t     band_reg, band_next;
    logic [23:0] wasm_reg, wasm_next;
    logic [1:0]  wcnt_reg, wcnt_next;
    logic [8:0]  fill_reg [4];
    logic [8:0]  fill_next [4];
    logic [1:0]  stop_reg, stop_next;
    event_t      ev_reg, ev_next;
    logic        evv_reg, evv_next;

    logic        take;
    logic [31:0] vacc;
    logic        vdone, vbad;
    logic [2:0]  wt;
    logic [31:0] vend;
    logic [1:0]  bidx;
    logic [8:0]  cap;
    logic        elem_done;
    phase_t      ph_fin;

    assign in_ready = !evv_reg || ev_ready;
    assign take = in_valid && in_ready;
    assign ev_valid = evv_reg;
    assign ev = ev_reg;

    always_comb
    begin
        bidx = band_reg[1:0];
        case (bidx)
            2'd0: cap = 9'(BASS_CAPACITY);
            2'd1: cap = 9'(LOWMID_CAPACITY);
            2'd2: cap = 9'(HIGHMID_CAPACITY);
            default: cap = 9'(TREBLE_CAPACITY);
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        acc_next = acc_reg;
        vcnt_next = vcnt_reg;
        pos_next = pos_reg;
        rend_next = rend_reg;
        inreg_next = inreg_reg;
        aend_next = aend_reg;
        band_next = band_reg;
        wasm_next = wasm_reg;
        wcnt_next = wcnt_reg;
        stop_next = stop_reg;
        for (int i = 0; i < 4; i++) fill_next[i] = fill_reg[i];
        ev_next = '0;
        evv_next = evv_reg && !ev_ready;
        vacc = acc_reg;
        vdone = 1'b0;
        vbad = 1'b0;
        elem_done = 1'b0;
        wt = '0;
        vend = '0;
        ph_fin = phase_reg;
        if (take)
        begin
            pos_next = sat_add(pos_reg, 32'd1);
            case (phase_reg)
                PH_TAG, PH_LEN, PH_SKIPVAR:
                begin
                    case (vcnt_reg)
                        3'd0: vacc = acc_reg | {25'd0, byte_in[6:0] & VarintPayloadMask};
                        3'd1: vacc = acc_reg | {18'd0, byte_in[6:0], 7'd0};
                        3'd2: vacc = acc_reg | {11'd0, byte_in[6:0], 14'd0};
                        3'd3: vacc = acc_reg | {4'd0, byte_in[6:0], 21'd0};
                        3'd4: vacc = acc_reg | {byte_in[3:0], 28'd0};
                        default: vacc = acc_reg;
                    endcase
                    acc_next = vacc;
                    if (!byte_in[7])
                    begin
                        vcnt_next = '0;
                        vdone = 1'b1;
                    end
                    else if (vcnt_reg >= 3'd4)
                        vbad = 1'b1;
                    else
                        vcnt_next = vcnt_reg + 3'd1;
                    vend = sat_add(pos_next, vacc);
                    wt = vacc[2:0] & WireTypeMask;
                    if (vbad)
                    begin
                        phase_next = PH_STOPPED;
                        stop_next = ST_MALFORMED;
                    end
                    else if (vdone)
                    begin
                        acc_next = '0;
                        if (phase_reg == PH_TAG)
                        begin
                            case (wt)
                                WT_LENGTH:
                                begin
                                    if (!inreg_reg)
                                        band_next = (vacc[31:3] == 29'd1) ? TGT_REGION : TGT_SKIP;
                                    else if (vacc[31:3] >= 29'd1 && vacc[31:3] <= 29'd4)
                                        band_next = target_t'(3'(vacc[4:3] - 2'd1));
                                    else
                                        band_next = TGT_SKIP;
                                    phase_next = PH_LEN;
                                end
                                WT_VARINT: phase_next = PH_SKIPVAR;
                                WT_FIXED64:
                                begin
                                    aend_next = sat_add(pos_next, 32'd8);
                                    phase_next = PH_SKIPBYTES;
                                end
                                WT_FIXED32:
                                begin
                                    aend_next = sat_add(pos_next, 32'd4);
                                    phase_next = PH_SKIPBYTES;
                                end
                                default:
                                begin
                                    phase_next = PH_STOPPED;
                                    stop_next = ST_MALFORMED;
                                end
                            endcase
                        end
                        else if (phase_reg == PH_LEN)
                        begin
                            if (band_reg == TGT_REGION)
                            begin
                                rend_next = vend;
                                inreg_next = (vacc != 32'd0);
                                phase_next = PH_TAG;
                            end
                            else
                            begin
                                aend_next = vend;
                                if (band_reg != TGT_SKIP)
                                begin
                                    fill_next[bidx] = '0;
                                    wasm_next = '0;
                                    wcnt_next = '0;
                                end
                                if (vacc != 32'd0)
                                    phase_next = (band_reg == TGT_SKIP) ? PH_SKIPBYTES : PH_ARRAY;
                                else
                                    elem_done = 1'b1;
                            end
                        end
                        else
                            elem_done = 1'b1;
                    end
                end
                PH_SKIPBYTES:
                    if (pos_next >= aend_reg) elem_done = 1'b1;
                PH_ARRAY:
                begin
                    if (wcnt_reg == 2'd3)
                    begin
                        if (fill_reg[bidx] < cap)
                        begin
                            ev_next.has_word = 1'b1;
                            ev_next.band = bidx;
                            ev_next.index = fill_reg[bidx][7:0];
                            ev_next.word = {byte_in, wasm_reg};
                            fill_next[bidx] = fill_reg[bidx] + 9'd1;
                        end
                        wasm_next = '0;
                        wcnt_next = '0;
                    end
                    else
                    begin
                        case (wcnt_reg)
                            2'd0: wasm_next = {wasm_reg[23:8], byte_in};
                            2'd1: wasm_next = {wasm_reg[23:16], byte_in, wasm_reg[7:0]};
                            default: wasm_next = {byte_in, wasm_reg[15:0]};
                        endcase
                        wcnt_next = wcnt_reg + 2'd1;
                    end
                    if (pos_next >= aend_reg)
                    begin
                        wasm_next = '0;
                        wcnt_next = '0;
                        elem_done = 1'b1;
                    end
                end
                default: ;
            endcase
            if (elem_done)
            begin
                phase_next = PH_TAG;
                if (inreg_reg && pos_next >= rend_reg) inreg_next = 1'b0;
            end
            ph_fin = phase_next;
            if (last_byte)
            begin
                ev_next.has_end = 1'b1;
                if (stop_next == ST_MALFORMED || ph_fin == PH_LEN || ph_fin == PH_SKIPVAR
                    || (ph_fin == PH_TAG && vcnt_next != 3'd0))
                    ev_next.status = ST_MALFORMED;
                else if (ph_fin == PH_SKIPBYTES || ph_fin == PH_ARRAY || inreg_next)
                    ev_next.status = ST_OVERRUN;
                else
                    ev_next.status = ST_OK;
                phase_next = PH_TAG;
                acc_next = '0;
                vcnt_next = '0;
                pos_next = '0;
                rend_next = '0;
                inreg_next = 1'b0;
                aend_next = '0;
                band_next = TGT_BASS;
                wasm_next = '0;
                wcnt_next = '0;
                stop_next = ST_OK;
                for (int i = 0; i < 4; i++) fill_next[i] = '0;
            end
            evv_next = ev_next.has_word || ev_next.has_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG;
            acc_reg <= '0;
            vcnt_reg <= '0;
            pos_reg <= '0;
            rend_reg <= '0;
            inreg_reg <= 1'b0;
            aend_reg <= '0;
            band_reg <= TGT_BASS;
            wasm_reg <= '0;
            wcnt_reg <= '0;
            stop_reg <= ST_OK;
            for (int i = 0; i < 4; i++) fill_reg[i] <= '0;
            evv_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg <= acc_next;
            vcnt_reg <= vcnt_next;
            pos_reg <= pos_next;
            rend_reg <= rend_next;
            inreg_reg <= inreg_next;
            aend_reg <= aend_next;
            band_reg <= band_next;
            wasm_reg <= wasm_next;
            wcnt_reg <= wcnt_next;
            stop_reg <= stop_next;
            for (int i = 0; i < 4; i++) fill_reg[i] <= fill_next[i];
            evv_reg <= evv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) ev_reg <= ev_next;
    end

    `ASSERT_IMPLIES(a_stop_status, clk, rst_n, phase_reg == PH_STOPPED, stop_reg == ST_MALFORMED)
    `ASSERT_IMPLIES(a_ev_nonempty, clk, rst_n, evv_reg, ev_reg.has_word || ev_reg.has_end)
    `ASSERT_NEXT(a_last_resets, clk, rst_n, take && last_byte, pos_reg == 32'd0)
endmodule

>>> rtl/hmd_emitter.sv
// ----------------------------------------------------------------------------
// hmd_emitter
// Back part: queues events and splits each into one or two result transactions.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module hmd_emitter (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             ev_valid,
    output logic             ev_ready,
    input  hmd_pkg::event_t  ev,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [47:0]      out_data,
    output logic             out_kind,
    output logic             out_last
);
    import hmd_pkg::*;

    event_t     q_mem [4];
    logic [1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       half_reg, half_next;
    event_t     head;
    logic       pop, push, end_now;

    assign head = q_mem[rp_reg];
    assign ev_ready = cnt_reg != 3'd4;
    assign push = ev_valid && ev_ready;
    assign out_valid = cnt_reg != 3'd0;
    // A word with an end report goes out as the word first, then the report.
    assign end_now = !head.has_word || half_reg;
    assign pop = out_valid && out_ready && (end_now || !head.has_end);

    always_comb
    begin
        out_data = '0;
        if (end_now)
            out_data[43:42] = head.status;
        else
        begin
            out_data[1:0] = head.band;
            out_data[9:2] = head.index;
            out_data[41:10] = head.word;
        end
        out_kind = end_now;
        out_last = end_now || !head.has_end;
        wp_next = push ? wp_reg + 2'd1 : wp_reg;
        rp_next = pop ? rp_reg + 2'd1 : rp_reg;
        cnt_next = cnt_reg + {2'd0, push} - {2'd0, pop};
        half_next = half_reg;
        if (out_valid && out_ready) half_next = !pop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
            half_reg <= 1'b0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
            half_reg <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) q_mem[wp_reg] <= ev;
    end

    `ASSERT_IMPLIES(a_cnt_max, clk, rst_n, 1'b1, cnt_reg <= 3'd4)
    `ASSERT_IMPLIES(a_half_both, clk, rst_n, half_reg, out_valid && head.has_word && head.has_end)
    `ASSERT_NEXT(a_half_then_pop, clk, rst_n, out_valid && out_ready && !pop, half_reg)
endmodule

>>> rtl/history_message_decoder.sv
// ----------------------------------------------------------------------------
// history_message_decoder
// Wire-format message decoder that extracts per-band sample words.
// ----------------------------------------------------------------------------
//  Channel | Direction | Transaction
//  s_axis  | in        | one message byte, tlast on the final byte
//  m_axis  | out       | one sample word or one end-of-message report (tuser)
//
// The parser takes one byte per cycle while its event register is empty or
// the emitter queue has room; results pass through that register, then the queue.
// A final byte that completes a word gives two result transactions, which
// the emitter drains from a four-entry event queue while bytes keep flowing.
// rst_n clears all parse state and the queue. Either side may stall freely.
// ----------------------------------------------------------------------------
module history_message_decoder #(
    parameter int unsigned BASS_CAPACITY    = hmd_pkg::DefaultCapacity,
    parameter int unsigned LOWMID_CAPACITY  = hmd_pkg::DefaultCapacity,
    parameter int unsigned HIGHMID_CAPACITY = hmd_pkg::DefaultCapacity,
    parameter int unsigned TREBLE_CAPACITY  = hmd_pkg::DefaultCapacity
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // byte_in
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // band, element_index, sample_bits, status, zero pad
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tuser,   // kind
    output logic        m_axis_tlast    // final_res
);
    import hmd_pkg::*;

    event_t ev;
    logic   ev_valid, ev_ready;

    hmd_parser #(
        .BASS_CAPACITY(BASS_CAPACITY),
        .LOWMID_CAPACITY(LOWMID_CAPACITY),
        .HIGHMID_CAPACITY(HIGHMID_CAPACITY),
        .TREBLE_CAPACITY(TREBLE_CAPACITY)
    ) u_parser (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .byte_in(s_axis_tdata), .last_byte(s_axis_tlast),
        .ev_valid(ev_valid), .ev_ready(ev_ready), .ev(ev)
    );

    // The emitter drives the result fields straight onto the output stream.
    hmd_emitter u_emitter (
        .clk(clk), .rst_n(rst_n),
        .ev_valid(ev_valid), .ev_ready(ev_ready), .ev(ev),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_data(m_axis_tdata), .out_kind(m_axis_tuser), .out_last(m_axis_tlast)
    );
endmodule
